// ===== design/elcd_pkg.sv =====
package elcd_pkg;

  localparam int LOAD_W = 9;
  localparam logic [LOAD_W-1:0] LOAD_MAX = 9'd511;
  localparam int CLIENT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [4:0] STARTS_MAX = 5'd31;

  localparam logic [1:0] ACT_REQUEST  = 2'd0;
  localparam logic [1:0] ACT_RESPONSE = 2'd1;
  localparam logic [1:0] ACT_ONLINE   = 2'd2;
  localparam logic [1:0] ACT_TICK     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_UP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd3;

  typedef enum logic [2:0] {
    IK_REQ,
    IK_ACK,
    IK_RESP,
    IK_ONLINE,
    IK_TICK
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [CLIENT_W-1:0] client;
    logic [7:0]          tag;
    logic [3:0]          worker;
  } item_t;

  typedef enum logic [2:0] {
    RK_DISPATCH = 3'd0,
    RK_FORWARD  = 3'd1,
    RK_ACK      = 3'd2,
    RK_ADDED    = 3'd3,
    RK_START    = 3'd4,
    RK_KILL     = 3'd5,
    RK_ERROR    = 3'd6
  } res_kind_t;

  typedef struct packed {
    res_kind_t           kind;
    logic [3:0]          target;
    logic [7:0]          tag;
    logic [CLIENT_W-1:0] client;
    logic                init;
    logic                last;
  } res_t;

endpackage

// ===== design/elcd_ram.sv =====
module elcd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/elcd_front.sv =====
module elcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [15:0]          in_client_id,
  input  logic                 in_last_request,
  input  logic [7:0]           in_response_tag,
  input  logic [3:0]           in_worker_index,
  output logic                 item_valid,
  output elcd_pkg::item_t      item,
  input  logic                 item_pop
);

  elcd_pkg::item_t e_r [2];
  elcd_pkg::item_t e_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  elcd_pkg::item_t cls;
  logic push;

  // classify the raw item
  always_comb begin
    cls.client = in_client_id;
    cls.tag    = in_response_tag;
    cls.worker = in_worker_index;
    case (in_action)
      elcd_pkg::ACT_REQUEST:  cls.kind = in_last_request ? elcd_pkg::IK_ACK
                                                         : elcd_pkg::IK_REQ;
      elcd_pkg::ACT_RESPONSE: cls.kind = elcd_pkg::IK_RESP;
      elcd_pkg::ACT_ONLINE:   cls.kind = elcd_pkg::IK_ONLINE;
      default:                cls.kind = elcd_pkg::IK_TICK;
    endcase
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = e_r[0];

  always_comb begin
    e_nxt   = e_r;
    cnt_nxt = cnt_r;
    if (item_pop && item_valid) begin
      e_nxt[0] = e_r[1];
      cnt_nxt  = cnt_nxt - 2'd1;
    end
    if (push) begin
      e_nxt[cnt_nxt[0]] = cls;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e_r <= e_nxt;
  end

endmodule

// ===== design/elcd_back.sv =====
module elcd_back #(
  parameter int WORKER_SLOTS = 16,
  parameter int TAG_DEPTH    = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [elcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [elcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  input  elcd_pkg::item_t                 item,
  output logic                            item_pop,
  output logic                            res_valid,
  output elcd_pkg::res_t                  res,
  input  logic                            res_ready
);

  localparam int WW   = $clog2(WORKER_SLOTS);
  localparam int CW   = $clog2(WORKER_SLOTS + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam int SW   = ((CW > 5) ? CW : 5) + 1;
  localparam int TW   = $clog2(TAG_DEPTH);
  localparam int OW   = $clog2(TAG_DEPTH + 1);
  localparam int RW   = ((TW + 1) > 8) ? (TW + 1) : 8;
  localparam int LW   = elcd_pkg::LOAD_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_REQ_INC, S_RESP_MOD, S_RESP_WB, S_SCAN, S_SCAN_END, S_DECIDE
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]    thr_r, thr_nxt;
  logic [7:0]    bound_r, bound_nxt;
  logic [4:0]    limit_r, limit_nxt;
  logic          policy_r, policy_nxt;

  logic [CW-1:0] active_r, active_nxt;
  logic [WW-1:0] chosen_r, chosen_nxt;
  logic [4:0]    starts_r, starts_nxt;
  logic          retire_r, retire_nxt;
  logic          ready_r, ready_nxt;
  logic [TW-1:0] tag_r, tag_nxt;
  logic [OW-1:0] outst_r, outst_nxt;

  logic [WW-1:0]   w_r, w_nxt;
  logic [TW-1:0]   dtag_r, dtag_nxt;
  logic [RW-1:0]   rt_r, rt_nxt;
  logic [CMPW-1:0] rw_r, rw_nxt;
  logic [WW-1:0]   clr_r, clr_nxt;
  logic [WW-1:0]   scan_r, scan_nxt;
  logic            pend_r, pend_nxt;
  logic [WW-1:0]   pidx_r, pidx_nxt;
  logic            stick_r, stick_nxt;
  logic [LW-1:0]   min_r, min_nxt;
  logic [WW-1:0]   midx_r, midx_nxt;
  logic [LW-1:0]   max_r, max_nxt;
  logic [LW-1:0]   lastld_r, lastld_nxt;

  elcd_pkg::res_t q_r [2];
  elcd_pkg::res_t q_nxt [2];
  logic [1:0]     qcnt_r, qcnt_nxt;

  logic          lw_en;
  logic [WW-1:0] lw_addr, lr_addr;
  logic [LW-1:0] lw_data, lr_data;
  logic          tw_en;
  logic [TW-1:0] tr_addr;
  logic [15:0]   tr_data;

  logic [WW-1:0] w_sel, nx_rr, nx_ll;
  logic [CW-1:0] rr_sum;
  logic          do_start, do_kill, do_mark;
  logic [CW-1:0] act_after;
  logic          ret_after;
  elcd_pkg::res_t p0, p1;
  logic [1:0]    push_n;

  elcd_ram #(.W(LW), .D(WORKER_SLOTS)) u_load (
    .clk(clk), .we(lw_en), .waddr(lw_addr), .wdata(lw_data),
    .raddr(lr_addr), .rdata(lr_data)
  );

  elcd_ram #(.W(elcd_pkg::CLIENT_W), .D(TAG_DEPTH)) u_tags (
    .clk(clk), .we(tw_en), .waddr(tag_r), .wdata(item.client),
    .raddr(tr_addr), .rdata(tr_data)
  );

  // keep the next choice off the last worker while it is retiring
  function automatic logic [WW-1:0] skip_last(input logic [WW-1:0] n,
                                               input logic retire,
                                               input logic [CW-1:0] act);
    logic [WW-1:0] r;
    r = n;
    if (retire && (CW'(n) == act - CW'(1)) && (n != '0)) begin
      r = n - WW'(1);
    end
    return r;
  endfunction

  assign w_sel  = (CW'(chosen_r) < active_r) ? chosen_r : '0;
  assign rr_sum = CW'(w_r) + CW'(1);
  assign nx_rr  = skip_last((rr_sum == active_r) ? '0 : rr_sum[WW-1:0], retire_r, active_r);
  assign nx_ll  = skip_last(midx_r, retire_r, active_r);

  assign do_start = (min_r > LW'(thr_r)) &&
                    ((SW'(active_r) + SW'(starts_r)) < SW'(limit_r));
  assign do_kill  = retire_r && (lastld_r == '0);
  assign act_after = do_kill ? (active_r - CW'(1)) : active_r;
  assign ret_after = do_kill ? 1'b0 : retire_r;
  assign do_mark   = !ret_after && (act_after > CW'(1)) && (max_r <= LW'(bound_r));

  assign res_valid = (qcnt_r != 2'd0);
  assign res       = q_r[0];

  always_comb begin
    state_nxt  = state_r;
    thr_nxt    = thr_r;
    bound_nxt  = bound_r;
    limit_nxt  = limit_r;
    policy_nxt = policy_r;
    active_nxt = active_r;
    chosen_nxt = chosen_r;
    starts_nxt = starts_r;
    retire_nxt = retire_r;
    ready_nxt  = ready_r;
    tag_nxt    = tag_r;
    outst_nxt  = outst_r;
    w_nxt      = w_r;
    dtag_nxt   = dtag_r;
    rt_nxt     = rt_r;
    rw_nxt     = rw_r;
    clr_nxt    = clr_r;
    scan_nxt   = scan_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    stick_nxt  = stick_r;
    min_nxt    = min_r;
    midx_nxt   = midx_r;
    max_nxt    = max_r;
    lastld_nxt = lastld_r;
    q_nxt      = q_r;
    qcnt_nxt   = qcnt_r;
    lw_en      = 1'b0;
    lw_addr    = '0;
    lw_data    = '0;
    lr_addr    = '0;
    tw_en      = 1'b0;
    tr_addr    = rt_r[TW-1:0];
    item_pop   = 1'b0;
    p0         = '0;
    p1         = '0;
    push_n     = 2'd0;

    if (cfg_we) begin
      case (cfg_index)
        elcd_pkg::CFG_SCALE_UP:   thr_nxt    = cfg_data;
        elcd_pkg::CFG_SCALE_DOWN: bound_nxt  = cfg_data;
        elcd_pkg::CFG_LIMIT:      limit_nxt  = cfg_data[4:0];
        elcd_pkg::CFG_POLICY:     policy_nxt = cfg_data[0];
        default: ;
      endcase
    end

    // fold in the load returned for the index issued last cycle
    if (pend_r) begin
      lastld_nxt = lr_data;
      if (pidx_r == '0) begin
        min_nxt  = lr_data;
        midx_nxt = '0;
        max_nxt  = lr_data;
      end else begin
        if (lr_data < min_r) begin
          min_nxt  = lr_data;
          midx_nxt = pidx_r;
        end
        if (lr_data > max_r) begin
          max_nxt = lr_data;
        end
      end
    end

    case (state_r)
      S_CLR: begin
        lw_en   = 1'b1;
        lw_addr = clr_r;
        if (clr_r == WW'(WORKER_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + WW'(1);
        end
      end
      S_IDLE: begin
        if (item_valid && (qcnt_r == 2'd0)) begin
          item_pop = 1'b1;
          case (item.kind)
            elcd_pkg::IK_ACK: begin
              p0.kind   = elcd_pkg::RK_ACK;
              p0.client = item.client;
              p0.last   = 1'b1;
              push_n    = 2'd1;
            end
            elcd_pkg::IK_REQ: begin
              if ((active_r == '0) || (outst_r == OW'(TAG_DEPTH))) begin
                p0.kind = elcd_pkg::RK_ERROR;
                p0.last = 1'b1;
                push_n  = 2'd1;
              end else begin
                w_nxt     = w_sel;
                lr_addr   = w_sel;
                tw_en     = 1'b1;
                dtag_nxt  = tag_r;
                tag_nxt   = (tag_r == TW'(TAG_DEPTH - 1)) ? '0 : tag_r + TW'(1);
                outst_nxt = outst_r + OW'(1);
                state_nxt = S_REQ_INC;
              end
            end
            elcd_pkg::IK_RESP: begin
              rt_nxt    = RW'(item.tag);
              rw_nxt    = CMPW'(item.worker);
              state_nxt = S_RESP_MOD;
            end
            elcd_pkg::IK_ONLINE: begin
              if (active_r == CW'(WORKER_SLOTS)) begin
                p0.kind = elcd_pkg::RK_ERROR;
              end else begin
                lw_en      = 1'b1;
                lw_addr    = active_r[WW-1:0];
                active_nxt = active_r + CW'(1);
                ready_nxt  = 1'b1;
                if (starts_r != 5'd0) begin
                  starts_nxt = starts_r - 5'd1;
                end
                p0.kind   = elcd_pkg::RK_ADDED;
                p0.target = 4'(active_r);
                p0.init   = !ready_r;
              end
              p0.last = 1'b1;
              push_n  = 2'd1;
            end
            elcd_pkg::IK_TICK: begin
              if (active_r != '0) begin
                stick_nxt = 1'b1;
                scan_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_REQ_INC: begin
        lw_en   = 1'b1;
        lw_addr = w_r;
        lw_data = (lr_data == elcd_pkg::LOAD_MAX) ? lr_data : lr_data + LW'(1);
        p0.kind   = elcd_pkg::RK_DISPATCH;
        p0.target = 4'(w_r);
        p0.tag    = 8'(dtag_r);
        p0.last   = 1'b1;
        push_n    = 2'd1;
        if (policy_r) begin
          chosen_nxt = nx_rr;
          state_nxt  = S_IDLE;
        end else begin
          stick_nxt = 1'b0;
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_RESP_MOD: begin
        // reduce the tag below the table depth, one subtraction a cycle
        if (rt_r >= RW'(TAG_DEPTH)) begin
          rt_nxt = rt_r - RW'(TAG_DEPTH);
        end else begin
          lr_addr   = rw_r[WW-1:0];
          state_nxt = S_RESP_WB;
        end
      end
      S_RESP_WB: begin
        if ((rw_r < CMPW'(active_r)) && (lr_data != '0)) begin
          lw_en   = 1'b1;
          lw_addr = rw_r[WW-1:0];
          lw_data = lr_data - LW'(1);
        end
        if (outst_r != '0) begin
          outst_nxt = outst_r - OW'(1);
        end
        p0.kind   = elcd_pkg::RK_FORWARD;
        p0.target = 4'(rw_r);
        p0.client = tr_data;
        p0.last   = 1'b1;
        push_n    = 2'd1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        lr_addr  = scan_r;
        pend_nxt = 1'b1;
        pidx_nxt = scan_r;
        if (CW'(scan_r) == active_r - CW'(1)) begin
          state_nxt = S_SCAN_END;
        end else begin
          scan_nxt = scan_r + WW'(1);
        end
      end
      S_SCAN_END: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        if (!stick_r) begin
          chosen_nxt = nx_ll;
        end else begin
          if (do_start && (starts_r != elcd_pkg::STARTS_MAX)) begin
            starts_nxt = starts_r + 5'd1;
          end
          active_nxt = act_after;
          retire_nxt = ret_after || do_mark;
          if (do_start) begin
            p0.kind   = elcd_pkg::RK_START;
            p0.target = 4'(active_r);
            p0.last   = !do_kill;
            p1.kind   = elcd_pkg::RK_KILL;
            p1.target = 4'(active_r - CW'(1));
            p1.last   = 1'b1;
          end else begin
            p0.kind   = elcd_pkg::RK_KILL;
            p0.target = 4'(active_r - CW'(1));
            p0.last   = 1'b1;
          end
          push_n = {1'b0, do_start} + {1'b0, do_kill};
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // results are only pushed into an empty queue
    if (push_n != 2'd0) begin
      q_nxt[0] = p0;
      q_nxt[1] = p1;
      qcnt_nxt = push_n;
    end else if (res_valid && res_ready) begin
      q_nxt[0] = q_r[1];
      qcnt_nxt = qcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      thr_r    <= 8'd7;
      bound_r  <= 8'd2;
      limit_r  <= 5'd4;
      policy_r <= 1'b0;
      active_r <= '0;
      chosen_r <= '0;
      starts_r <= 5'd0;
      retire_r <= 1'b0;
      ready_r  <= 1'b0;
      tag_r    <= '0;
      outst_r  <= '0;
      clr_r    <= '0;
      pend_r   <= 1'b0;
      qcnt_r   <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      thr_r    <= thr_nxt;
      bound_r  <= bound_nxt;
      limit_r  <= limit_nxt;
      policy_r <= policy_nxt;
      active_r <= active_nxt;
      chosen_r <= chosen_nxt;
      starts_r <= starts_nxt;
      retire_r <= retire_nxt;
      ready_r  <= ready_nxt;
      tag_r    <= tag_nxt;
      outst_r  <= outst_nxt;
      clr_r    <= clr_nxt;
      pend_r   <= pend_nxt;
      qcnt_r   <= qcnt_nxt;
    end
    w_r      <= w_nxt;
    dtag_r   <= dtag_nxt;
    rt_r     <= rt_nxt;
    rw_r     <= rw_nxt;
    scan_r   <= scan_nxt;
    pidx_r   <= pidx_nxt;
    stick_r  <= stick_nxt;
    min_r    <= min_nxt;
    midx_r   <= midx_nxt;
    max_r    <= max_nxt;
    lastld_r <= lastld_nxt;
    q_r      <= q_nxt;
  end

endmodule

// ===== design/elastic_least_connection_dispatcher_top.sv =====
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    action, client_id, last_request, tag, worker
// out_      output     out_valid / out_ready  kind, worker, tag, client, init, last
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// Items enter a two-deep input queue and are executed one at a time by the back end.
// Ack, error, worker-online and an idle-pool tick are handled in the idle state; a round-robin
// dispatch adds a load update, a response a tag reduction per tag wrap and a write-back, and a tick
// and a least-connection dispatch a serial scan of the load memory over the active workers.
// Reset is synchronous; after it the load memory is cleared slot by slot before any item is executed.
// A held result stalls the back end only; the input queue keeps taking items until it is full.
module elastic_least_connection_dispatcher_top #(
  parameter int WORKER_SLOTS = 16,
  parameter int TAG_DEPTH    = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [elcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [elcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [15:0]                     in_client_id,
  input  logic                            in_last_request,
  input  logic [7:0]                      in_response_tag,
  input  logic [3:0]                      in_worker_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_result_kind,
  output logic [3:0]                      out_target_worker,
  output logic [7:0]                      out_assigned_tag,
  output logic [15:0]                     out_client_out,
  output logic                            out_init_complete,
  output logic                            out_last_of_run
);

  logic            item_valid;
  logic            item_pop;
  elcd_pkg::item_t item;
  elcd_pkg::res_t  res;

  elcd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_client_id(in_client_id),
    .in_last_request(in_last_request), .in_response_tag(in_response_tag),
    .in_worker_index(in_worker_index),
    .item_valid(item_valid), .item(item), .item_pop(item_pop)
  );

  elcd_back #(.WORKER_SLOTS(WORKER_SLOTS), .TAG_DEPTH(TAG_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item(item), .item_pop(item_pop),
    .res_valid(out_valid), .res(res), .res_ready(out_ready)
  );

  assign out_result_kind   = res.kind;
  assign out_target_worker = res.target;
  assign out_assigned_tag  = res.tag;
  assign out_client_out    = res.client;
  assign out_init_complete = res.init;
  assign out_last_of_run   = res.last;

endmodule

// ===== design/elcd_chk.sv =====
module elcd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_result_kind,
  input logic [7:0]  out_assigned_tag,
  input logic        out_init_complete,
  input logic        out_last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_init_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_init_complete |-> out_result_kind == elcd_pkg::RK_ADDED)
    else $error("init flag on a result other than worker added");

  a_tag_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != elcd_pkg::RK_DISPATCH |-> out_assigned_tag == 8'd0)
    else $error("tag on a non-dispatch result");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != elcd_pkg::RK_START |-> out_last_of_run)
    else $error("only a start may be followed by another result of the same item");

endmodule

bind elastic_least_connection_dispatcher_top elcd_chk u_elcd_chk (.*);

// ===== tb/sv/testbench.sv =====
module testbench;
  import elcd_pkg::*;

  localparam int NUM_WORKERS = 16;
  localparam int NUM_TAGS    = 256;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 64;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] client;
    logic        last_req;
    logic [7:0]  tag;
    logic [3:0]  worker;
  } stim_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [15:0] in_client_id;
  logic        in_last_request;
  logic [7:0]  in_response_tag;
  logic [3:0]  in_worker_index;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_result_kind;
  logic [3:0]  out_target_worker;
  logic [7:0]  out_assigned_tag;
  logic [15:0] out_client_out;
  logic        out_init_complete;
  logic        out_last_of_run;

  elastic_least_connection_dispatcher_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_client_id(in_client_id), .in_last_request(in_last_request),
    .in_response_tag(in_response_tag), .in_worker_index(in_worker_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_target_worker(out_target_worker), .out_assigned_tag(out_assigned_tag),
    .out_client_out(out_client_out), .out_init_complete(out_init_complete),
    .out_last_of_run(out_last_of_run)
  );

  // dispatcher shadow state
  logic [8:0]  load_of [NUM_WORKERS];
  logic [4:0]  n_active;
  logic [3:0]  pick_w;
  logic [4:0]  starts_open;
  logic        retiring;
  logic        seen_first;
  logic [7:0]  tag_ctr;
  logic [8:0]  in_flight;
  logic [15:0] client_of [NUM_TAGS];
  bit          tag_written [NUM_TAGS];
  logic [7:0]  up_thr;
  logic [7:0]  down_bound;
  logic [4:0]  worker_cap;
  logic        rr_mode;

  stim_t pending_items[$];
  res_t  expected_results[$];
  logic [7:0] open_tags[$];

  int send_idle;
  int recv_stall;
  int errors;
  int mismatches;
  int cycles;
  stim_t drv_item;
  res_t  want;

  function automatic int least_loaded();
    int best;
    best = 0;
    for (int i = 1; i < n_active && i < NUM_WORKERS; i++)
      if (load_of[i] < load_of[best]) best = i;
    return best;
  endfunction

  function automatic int peak_load();
    int m;
    m = 0;
    for (int i = 0; i < n_active && i < NUM_WORKERS; i++)
      if (load_of[i] > m) m = load_of[i];
    return m;
  endfunction

  function automatic res_t mk_res(res_kind_t k, int w, int t, int cl, bit init);
    res_t r;
    r.kind   = k;
    r.target = w[3:0];
    r.tag    = t[7:0];
    r.client = cl[15:0];
    r.init   = init;
    r.last   = 1'b0;
    return r;
  endfunction

  // advance the shadow state by one item and queue the results it causes
  task automatic predict_dispatch(input stim_t s);
    res_t outs[2];
    int   n;
    int   w;
    int   nx;
    int   last_w;
    n = 0;
    case (s.action)
      ACT_REQUEST: begin
        if (s.last_req) begin
          outs[n++] = mk_res(RK_ACK, 0, 0, int'(s.client), 0);
        end else if (n_active == 0 || in_flight >= NUM_TAGS) begin
          outs[n++] = mk_res(RK_ERROR, 0, 0, 0, 0);
        end else begin
          w = (pick_w < n_active) ? int'(pick_w) : 0;
          client_of[tag_ctr] = s.client;
          tag_written[tag_ctr] = 1;
          open_tags.insert(open_tags.size(), tag_ctr);
          outs[n++] = mk_res(RK_DISPATCH, w, int'(tag_ctr), 0, 0);
          tag_ctr = tag_ctr + 8'd1;
          in_flight = in_flight + 9'd1;
          if (load_of[w] < LOAD_MAX) load_of[w] = load_of[w] + 9'd1;
          if (rr_mode) nx = (w + 1) % int'(n_active);
          else nx = least_loaded();
          if (retiring && nx == int'(n_active) - 1 && nx > 0) nx--;
          pick_w = nx[3:0];
        end
      end
      ACT_RESPONSE: begin
        w = int'(s.worker);
        if (w < n_active && load_of[w] > 0) load_of[w] = load_of[w] - 9'd1;
        if (in_flight > 0) in_flight = in_flight - 9'd1;
        outs[n++] = mk_res(RK_FORWARD, w, 0, int'(client_of[s.tag]), 0);
      end
      ACT_ONLINE: begin
        if (n_active >= NUM_WORKERS) begin
          outs[n++] = mk_res(RK_ERROR, 0, 0, 0, 0);
        end else begin
          w = int'(n_active);
          load_of[w] = '0;
          n_active = n_active + 5'd1;
          outs[n++] = mk_res(RK_ADDED, w, 0, 0, !seen_first);
          seen_first = 1'b1;
          if (starts_open > 0) starts_open = starts_open - 5'd1;
        end
      end
      default: begin
        if (n_active > 0 && load_of[least_loaded()] > up_thr &&
            int'(n_active) + int'(starts_open) < int'(worker_cap)) begin
          if (starts_open < STARTS_MAX) starts_open = starts_open + 5'd1;
          outs[n++] = mk_res(RK_START, int'(n_active), 0, 0, 0);
        end
        if (retiring && n_active > 0 && load_of[int'(n_active) - 1] == 0) begin
          last_w = int'(n_active) - 1;
          load_of[last_w] = '0;
          n_active = last_w[4:0];
          retiring = 1'b0;
          outs[n++] = mk_res(RK_KILL, last_w, 0, 0, 0);
        end
        if (!retiring && n_active > 1 && peak_load() <= down_bound) retiring = 1'b1;
      end
    endcase
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.insert(expected_results.size(), outs[i]);
  endtask

  task automatic send_item(input stim_t s);
    predict_dispatch(s);
    pending_items.insert(pending_items.size(), s);
  endtask

  function automatic stim_t noise_item(logic [1:0] act);
    stim_t s;
    s.action   = act;
    s.client   = 16'($urandom_range(16'hffff));
    s.last_req = 1'b0;
    s.tag      = 8'($urandom_range(255));
    s.worker   = 4'($urandom_range(15));
    return s;
  endfunction

  task automatic send_action(input logic [1:0] act);
    send_item(noise_item(act));
  endtask

  task automatic send_response();
    stim_t s;
    int    k;
    s = noise_item(ACT_RESPONSE);
    if (open_tags.size() > 0 && $urandom_range(99) < 85) begin
      k = int'($urandom_range(open_tags.size() - 1));
      s.tag = open_tags[k];
      open_tags.delete(k);
    end else begin
      // stale tag: only ones that were written at some point
      do s.tag = 8'($urandom_range(255)); while (!tag_written[s.tag]);
    end
    if (n_active > 0 && $urandom_range(99) < 85)
      s.worker = 4'($urandom_range(int'(n_active) - 1));
    send_item(s);
  endtask

  task automatic send_random(input int count);
    int    roll;
    stim_t s;
    bit    any_tag;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      any_tag = open_tags.size() > 0 || tag_written[tag_ctr - 8'd1];
      if (roll < 40) begin
        s = noise_item(ACT_REQUEST);
        s.last_req = ($urandom_range(99) < 5);
        send_item(s);
      end else if (roll < 70 && any_tag) begin
        send_response();
      end else if (roll < 90) begin
        send_action(ACT_TICK);
      end else begin
        send_action(ACT_ONLINE);
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SCALE_UP:   up_thr = val;
      CFG_SCALE_DOWN: down_bound = val;
      CFG_LIMIT:      worker_cap = val[4:0];
      default:        rr_mode = val[0];
    endcase
  endtask

  task automatic set_mode(input int idle, input int stall);
    send_idle  = idle;
    recv_stall = stall;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // drive the next item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        drv_item = pending_items.pop_front();
        in_valid        <= 1'b1;
        in_action       <= drv_item.action;
        in_client_id    <= drv_item.client;
        in_last_request <= drv_item.last_req;
        in_response_tag <= drv_item.tag;
        in_worker_index <= drv_item.worker;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10)
            $display("unexpected result kind=%0d worker=%0d", out_result_kind,
                     out_target_worker);
        end else begin
          want = expected_results.pop_front();
          if (out_result_kind !== want.kind || out_target_worker !== want.target ||
              out_assigned_tag !== want.tag || out_client_out !== want.client ||
              out_init_complete !== want.init || out_last_of_run !== want.last) begin
            errors++;
            if (mismatches++ < 10) begin
              $display("mismatch exp k=%0d w=%0d t=%0d c=%0h i=%0b l=%0b",
                       want.kind, want.target, want.tag, want.client, want.init,
                       want.last);
              $display("         got k=%0d w=%0d t=%0d c=%0h i=%0b l=%0b",
                       out_result_kind, out_target_worker, out_assigned_tag,
                       out_client_out, out_init_complete, out_last_of_run);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_t s;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = '0;
    in_client_id = '0;
    in_last_request = 1'b0;
    in_response_tag = '0;
    in_worker_index = '0;
    out_ready = 1'b0;
    errors = 0;
    mismatches = 0;
    cycles = 0;
    set_mode(0, 0);
    for (int i = 0; i < NUM_WORKERS; i++) load_of[i] = '0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      client_of[i] = '0;
      tag_written[i] = 0;
    end
    n_active = '0;
    pick_w = '0;
    starts_open = '0;
    retiring = 1'b0;
    seen_first = 1'b0;
    tag_ctr = '0;
    in_flight = '0;
    up_thr = 8'd7;
    down_bound = 8'd2;
    worker_cap = 5'd4;
    rr_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (NUM_WORKERS + 8) @(posedge clk);

    write_cfg(CFG_SCALE_UP, 8'd0);
    write_cfg(CFG_SCALE_DOWN, 8'd0);
    write_cfg(CFG_LIMIT, 8'd16);
    write_cfg(CFG_POLICY, 8'd0);

    // directed: empty pool, acks, first worker, pool overflow
    send_action(ACT_REQUEST);
    s = noise_item(ACT_REQUEST);
    s.last_req = 1'b1;
    s.client = 16'hffff;
    send_item(s);
    send_action(ACT_TICK);
    send_action(ACT_ONLINE);
    s = noise_item(ACT_REQUEST);
    s.client = 16'h0000;
    send_item(s);
    send_action(ACT_TICK);
    s = noise_item(ACT_RESPONSE);
    s.tag = 8'd0;
    s.worker = 4'd15;
    send_item(s);
    s.worker = 4'd0;
    send_item(s);
    for (int i = 0; i < NUM_WORKERS; i++) send_action(ACT_ONLINE);
    send_action(ACT_TICK);
    drain();

    // fill the tag table, hit the full case, then answer most of them
    write_cfg(CFG_POLICY, 8'd1);
    for (int i = 0; i < NUM_TAGS + 3; i++) send_action(ACT_REQUEST);
    drain();
    set_mode(50, 50);
    while (open_tags.size() > 96) send_response();
    send_action(ACT_TICK);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_mode(0, 0);
          write_cfg(CFG_SCALE_UP, 8'd255);
          write_cfg(CFG_SCALE_DOWN, 8'd255);
          write_cfg(CFG_LIMIT, 8'd1);
          write_cfg(CFG_POLICY, 8'd0);
        end
        1: begin
          set_mode(50, 0);
          write_cfg(CFG_SCALE_UP, 8'd1);
          write_cfg(CFG_SCALE_DOWN, 8'd1);
          write_cfg(CFG_LIMIT, 8'd16);
          write_cfg(CFG_POLICY, 8'd1);
        end
        2: begin
          set_mode(0, 50);
          write_cfg(CFG_SCALE_UP, 8'd7);
          write_cfg(CFG_SCALE_DOWN, 8'd2);
          write_cfg(CFG_LIMIT, 8'd4);
          write_cfg(CFG_POLICY, 8'd0);
        end
        default: begin
          set_mode(19, 19);
          write_cfg(CFG_SCALE_UP, 8'($urandom_range(3)));
          write_cfg(CFG_SCALE_DOWN, 8'($urandom_range(4)));
          write_cfg(CFG_LIMIT, 8'($urandom_range(16, 1)));
          write_cfg(CFG_POLICY, 8'($urandom_range(1)));
        end
      endcase
      send_random(10);
      // hold off until the block has caught up
      drain();
      send_random(10);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== elastic_least_connection_dispatcher_top.f =====
design/elcd_pkg.sv
design/elcd_ram.sv
design/elcd_front.sv
design/elcd_back.sv
design/elastic_least_connection_dispatcher_top.sv
design/elcd_chk.sv
tb/sv/testbench.sv
